// ----- hw/rtl/vai_pkg.sv -----
`timescale 1ns / 1ps
package vai_pkg;

  // atom count limit and the width that holds it
  localparam int unsigned MaxAtoms = 4096;
  localparam int unsigned CntW     = $clog2(MaxAtoms + 1);

  // shared arithmetic unit widths
  localparam int unsigned MulAW = 64;
  localparam int unsigned MulBW = 32;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned DivNW = 96;
  localparam int unsigned DivDW = 64;

  // configuration port
  localparam int unsigned CfgW    = 40;
  localparam int unsigned CfgIdxW = 2;

  // register reset values
  localparam logic [31:0] BoxRst = 32'd0;
  localparam logic [31:0] TsRst  = 32'd268435456;
  localparam logic [31:0] FtaRst = 32'd161868;
  localparam logic [39:0] KbRst  = 40'd94748600;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FLAG = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [1:0] {
    OP_KICK   = 2'd0,
    OP_DRIFT  = 2'd1,
    OP_ENERGY = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_BOX = 2'd0,
    CFG_TS  = 2'd1,
    CFG_FTA = 2'd2,
    CFG_KB  = 2'd3
  } cfg_idx_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_F_TS,
    MUL_P_FTA,
    MUL_V_TS,
    MUL_V_V,
    MUL_SQ_M,
    MUL_KB_N
  } mul_sel_e;

  // divider operand selection
  typedef enum logic [1:0] {
    DIV_KICK,
    DIV_WRAP,
    DIV_ENERGY,
    DIV_TEMP
  } div_sel_e;

  // result update after a unit finishes
  typedef enum logic [2:0] {
    POST_NONE,
    POST_KICK,
    POST_DRIFT_S,
    POST_DRIFT,
    POST_SQ,
    POST_ENERGY,
    POST_TEMP
  } post_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [23:0]        mass;
    logic               last_atom;
  } vai_in_t;

  typedef struct packed {
    logic signed [31:0] new_a;
    logic signed [31:0] new_b;
    logic signed [31:0] new_c;
    logic signed [7:0]  wrap_x;
    logic signed [7:0]  wrap_y;
    logic signed [7:0]  wrap_z;
    logic [47:0]        kinetic_total;
    logic [31:0]        temperature_k;
    logic [1:0]         status;
    logic               result_last;
  } vai_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_go;
    mul_sel_e   mul_sel;
    logic       div_go;
    div_sel_e   div_sel;
    post_e      post;
    logic [1:0] axis;
    logic       out_load;
  } vai_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic last;
    logic mul_done;
    logic div_done;
  } vai_sts_t;

endpackage

// ----- hw/rtl/vai_mul.sv -----
`timescale 1ns / 1ps
module vai_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vai_pkg::MulAW-1:0] a_i,
  input  logic [vai_pkg::MulBW-1:0] b_i,
  output logic                      done_o,
  output logic [vai_pkg::MulPW-1:0] p_o
);
  import vai_pkg::*;

  localparam int unsigned CW = $clog2(MulBW);

  logic          run_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [MulPW-1:0] acc_q;
  logic [MulPW-1:0] a_q;
  logic [MulBW-1:0] b_q;

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MulBW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift and add, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= MulPW'(a_i);
      b_q   <= b_i;
    end else if (run_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- hw/rtl/vai_div.sv -----
`timescale 1ns / 1ps
module vai_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vai_pkg::DivNW-1:0] num_i,
  input  logic [vai_pkg::DivDW-1:0] den_i,
  output logic                      done_o,
  output logic [vai_pkg::DivNW-1:0] quot_o,
  output logic [vai_pkg::DivDW-1:0] rem_o
);
  import vai_pkg::*;

  localparam int unsigned CW = $clog2(DivNW);

  logic             run_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DivNW-1:0] num_q;
  logic [DivNW-1:0] quo_q;
  logic [DivDW-1:0] den_q;
  logic [DivDW-1:0] rem_q;
  logic [DivDW:0]   trial;
  logic             ge;

  // restoring step: shift in one numerator bit, subtract when it fits
  assign trial = {rem_q, num_q[DivNW-1]};
  assign ge    = trial >= {1'b0, den_q};

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DivNW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? DivDW'(trial - {1'b0, den_q}) : trial[DivDW-1:0];
      num_q <= num_q << 1;
      quo_q <= {quo_q[DivNW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/vai_dp.sv -----
`timescale 1ns / 1ps
module vai_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vai_pkg::vai_in_t            in_word_i,
  input  logic                        cfg_we_i,
  input  logic [vai_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vai_pkg::CfgW-1:0]    cfg_data_i,
  input  vai_pkg::vai_cmd_t           cmd_i,
  output vai_pkg::vai_sts_t           sts_o,
  output vai_pkg::vai_out_t           out_word_o
);
  import vai_pkg::*;

  // configuration and running state
  logic [31:0]     box_q;
  logic [31:0]     ts_q;
  logic [31:0]     fta_q;
  logic [39:0]     kb_q;
  logic [47:0]     energy_q, energy_d;
  logic [CntW-1:0] count_q, count_d;

  // working registers
  vai_in_t            in_q;
  vai_out_t           out_q;
  logic signed [31:0] res_q [3];
  logic signed [31:0] res_d [3];
  logic signed [7:0]  wrap_q [3];
  logic signed [7:0]  wrap_d [3];
  logic               flag_q, flag_d;
  logic               sat_q, sat_d;
  logic signed [34:0] s_q, s_d;
  logic [63:0]        sumsq_q, sumsq_d;
  logic [47:0]        ktot_q, ktot_d;
  logic [31:0]        temp_q, temp_d;

  // unit connections
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;
  logic             mul_done;
  logic [DivNW-1:0] div_num;
  logic [DivDW-1:0] div_den;
  logic [DivNW-1:0] div_quot;
  logic [DivDW-1:0] div_rem;
  logic             div_done;

  // per axis operands
  logic signed [31:0] p_sel, v_sel, f_sel;
  logic [31:0]        v_mag, f_mag;
  logic [CntW+1:0]    cnt3;

  // kick terms
  logic               kq_big;
  logic [35:0]        kick_t;

  // drift and wrap terms
  logic [34:0]        dp_pos, dp_mag;
  logic signed [34:0] s_new;
  logic [37:0]        wnum, wnum_mag;
  logic               wnum_neg, r_nz, w_fix;
  logic [33:0]        half;
  logic [40:0]        n_mag;
  logic               n_big;
  logic [7:0]         n_val;

  // energy terms
  logic [48:0]        e_add;
  logic               e_big;
  logic               t_big;

  function automatic logic fits32(input logic [35:0] t);
    return (&t[35:31]) || !(|t[35:31]);
  endfunction

  function automatic logic [31:0] clamp32(input logic [35:0] t);
    logic [31:0] r;
    if (fits32(t)) r = t[31:0];
    else if (t[35]) r = 32'h8000_0000;
    else r = 32'h7fff_ffff;
    return r;
  endfunction

  // axis selection
  always_comb begin
    p_sel = in_q.pos_x;
    v_sel = in_q.vel_x;
    f_sel = in_q.force_x;
    unique case (cmd_i.axis)
      2'd0: begin
        p_sel = in_q.pos_x;
        v_sel = in_q.vel_x;
        f_sel = in_q.force_x;
      end
      2'd1: begin
        p_sel = in_q.pos_y;
        v_sel = in_q.vel_y;
        f_sel = in_q.force_y;
      end
      2'd2: begin
        p_sel = in_q.pos_z;
        v_sel = in_q.vel_z;
        f_sel = in_q.force_z;
      end
      default: ;
    endcase
  end

  assign v_mag = v_sel[31] ? (32'd0 - v_sel) : v_sel;
  assign f_mag = f_sel[31] ? (32'd0 - f_sel) : f_sel;
  assign cnt3  = {1'b0, count_q, 1'b0} + {2'b00, count_q};

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      MUL_F_TS: begin
        mul_a = MulAW'(f_mag);
        mul_b = ts_q;
      end
      MUL_P_FTA: begin
        mul_a = mul_p[MulAW-1:0];
        mul_b = fta_q;
      end
      MUL_V_TS: begin
        mul_a = MulAW'(v_mag);
        mul_b = ts_q;
      end
      MUL_V_V: begin
        mul_a = MulAW'(v_mag);
        mul_b = v_mag;
      end
      MUL_SQ_M: begin
        mul_a = sumsq_q;
        mul_b = MulBW'(in_q.mass);
      end
      MUL_KB_N: begin
        mul_a = MulAW'(kb_q);
        mul_b = MulBW'(cnt3);
      end
      default: ;
    endcase
  end

  // wrap numerator 2s + L
  assign wnum     = {{2{s_q[34]}}, s_q, 1'b0} + {6'd0, box_q};
  assign wnum_neg = wnum[37];
  assign wnum_mag = wnum_neg ? (38'd0 - wnum) : wnum;

  // divider operands
  always_comb begin
    div_num = mul_p;
    div_den = '0;
    unique case (cmd_i.div_sel)
      DIV_KICK: begin
        div_num = mul_p;
        div_den = {9'd0, in_q.mass, 31'd0};
      end
      DIV_WRAP: begin
        div_num = DivNW'(wnum_mag);
        div_den = {31'd0, box_q, 1'b0};
      end
      DIV_ENERGY: begin
        div_num = mul_p;
        div_den = {17'd0, fta_q, 15'd0};
      end
      DIV_TEMP: begin
        div_num = {15'd0, energy_q, 33'd0};
        div_den = mul_p[DivDW-1:0];
      end
      default: ;
    endcase
  end

  vai_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  vai_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // kick: quotient above 2^33 saturates outright
  assign kq_big = (|div_quot[95:34]) || (div_quot[33] && (|div_quot[32:0]));
  assign kick_t = {{4{v_sel[31]}}, v_sel} +
                  (f_sel[31] ? (36'd0 - {2'b00, div_quot[33:0]}) : {2'b00, div_quot[33:0]});

  // drift: floor of the scaled step, rounding down for negative velocity
  assign dp_pos = {7'd0, mul_p[63:36]};
  assign dp_mag = dp_pos + {34'd0, |mul_p[35:0]};
  assign s_new  = {{3{p_sel[31]}}, p_sel} + (v_sel[31] ? (35'd0 - dp_mag) : dp_pos);

  // wrapped position from the remainder, image count from the quotient
  assign r_nz  = |div_rem;
  assign w_fix = wnum_neg && r_nz;
  assign half  = w_fix ? ({2'b00, box_q} - {1'b0, div_rem[32:0]})
                       : ({1'b0, div_rem[32:0]} - {2'b00, box_q});
  assign n_mag = {1'b0, div_quot[39:0]} + {40'd0, w_fix};
  assign n_big = (|div_quot[95:40]) || (wnum_neg ? (n_mag > 41'd128) : (n_mag > 41'd127));
  assign n_val = n_big ? (wnum_neg ? 8'h80 : 8'h7f)
                       : (wnum_neg ? (8'd0 - n_mag[7:0]) : n_mag[7:0]);

  // energy accumulate and temperature range
  assign e_add = {1'b0, energy_q} + {1'b0, div_quot[47:0]};
  assign e_big = (|div_quot[95:48]) || e_add[48];
  assign t_big = |div_quot[95:32];

  // result updates
  always_comb begin
    res_d    = res_q;
    wrap_d   = wrap_q;
    flag_d   = flag_q;
    sat_d    = sat_q;
    s_d      = s_q;
    sumsq_d  = sumsq_q;
    energy_d = energy_q;
    count_d  = count_q;
    ktot_d   = ktot_q;
    temp_d   = temp_q;
    unique case (cmd_i.post)
      POST_NONE: ;
      POST_KICK: begin
        if (in_q.mass == 24'd0) begin
          flag_d = 1'b1;
          res_d[cmd_i.axis] = v_sel;
        end else if (kq_big) begin
          sat_d = 1'b1;
          res_d[cmd_i.axis] = f_sel[31] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          if (!fits32(kick_t)) sat_d = 1'b1;
          res_d[cmd_i.axis] = clamp32(kick_t);
        end
      end
      POST_DRIFT_S: s_d = s_new;
      POST_DRIFT: begin
        if (box_q == 32'd0) begin
          flag_d = 1'b1;
          if (!fits32({s_q[34], s_q})) sat_d = 1'b1;
          res_d[cmd_i.axis] = clamp32({s_q[34], s_q});
        end else begin
          if (n_big) sat_d = 1'b1;
          res_d[cmd_i.axis]  = half[32:1];
          wrap_d[cmd_i.axis] = n_val;
        end
      end
      POST_SQ: begin
        sumsq_d = ((cmd_i.axis == 2'd0) ? 64'd0 : sumsq_q) + mul_p[63:0];
      end
      POST_ENERGY: begin
        if (in_q.mass == 24'd0) flag_d = 1'b1;
        if (fta_q == 32'd0) begin
          flag_d = 1'b1;
        end else if (e_big) begin
          sat_d    = 1'b1;
          energy_d = '1;
        end else begin
          energy_d = e_add[47:0];
        end
        if (count_q < CntW'(MaxAtoms)) count_d = count_q + 1'b1;
        else sat_d = 1'b1;
        ktot_d = energy_d;
      end
      POST_TEMP: begin
        if (kb_q == 40'd0) begin
          flag_d = 1'b1;
        end else if (t_big) begin
          sat_d  = 1'b1;
          temp_d = '1;
        end else begin
          temp_d = div_quot[31:0];
        end
        energy_d = '0;
        count_d  = '0;
      end
      default: ;
    endcase
  end

  // configuration and energy state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q    <= BoxRst;
      ts_q     <= TsRst;
      fta_q    <= FtaRst;
      kb_q     <= KbRst;
      energy_q <= '0;
      count_q  <= '0;
    end else begin
      energy_q <= energy_d;
      count_q  <= count_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BOX: box_q <= cfg_data_i[31:0];
          CFG_TS:  ts_q  <= cfg_data_i[31:0];
          CFG_FTA: fta_q <= cfg_data_i[31:0];
          CFG_KB:  kb_q  <= cfg_data_i;
        endcase
      end
    end
  end

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q    <= in_word_i;
      flag_q  <= 1'b0;
      sat_q   <= 1'b0;
      ktot_q  <= '0;
      temp_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        res_q[i]  <= '0;
        wrap_q[i] <= '0;
      end
    end else begin
      flag_q <= flag_d;
      sat_q  <= sat_d;
      ktot_q <= ktot_d;
      temp_q <= temp_d;
      res_q  <= res_d;
      wrap_q <= wrap_d;
    end
    s_q     <= s_d;
    sumsq_q <= sumsq_d;
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.new_a         <= res_q[0];
      out_q.new_b         <= res_q[1];
      out_q.new_c         <= res_q[2];
      out_q.wrap_x        <= wrap_q[0];
      out_q.wrap_y        <= wrap_q[1];
      out_q.wrap_z        <= wrap_q[2];
      out_q.kinetic_total <= ktot_q;
      out_q.temperature_k <= temp_q;
      out_q.status        <= sat_q ? ST_SAT : (flag_q ? ST_FLAG : ST_OK);
      out_q.result_last   <= (in_q.op == OP_ENERGY) && in_q.last_atom;
    end
  end

  assign out_word_o     = out_q;
  assign sts_o.op       = op_e'(in_q.op);
  assign sts_o.last     = in_q.last_atom;
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;

endmodule

// ----- hw/rtl/vai_ctrl.sv -----
`timescale 1ns / 1ps
module vai_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  vai_pkg::vai_sts_t  sts_i,
  output vai_pkg::vai_cmd_t  cmd_o
);
  import vai_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_K_MUL1,
    S_K_MUL2,
    S_K_DIV,
    S_K_FIN,
    S_D_MUL,
    S_D_SUM,
    S_D_DIV,
    S_D_FIN,
    S_E_SQ,
    S_E_SQACC,
    S_E_MUL,
    S_E_DIV,
    S_E_ACC,
    S_T_MUL,
    S_T_DIV,
    S_T_FIN,
    S_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] axis_q;
  logic       mul_go_q;
  logic       div_go_q;
  logic       out_valid_q;
  logic       load;
  logic       out_load;
  mul_sel_e   mul_sel;
  div_sel_e   div_sel;
  post_e      post;

  assign load       = (state_q == S_IDLE) && in_valid_i;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  // operand and update selection per state
  always_comb begin
    mul_sel = MUL_F_TS;
    div_sel = DIV_KICK;
    post    = POST_NONE;
    unique case (state_q)
      S_K_MUL1:  mul_sel = MUL_F_TS;
      S_K_MUL2:  mul_sel = MUL_P_FTA;
      S_K_DIV:   div_sel = DIV_KICK;
      S_K_FIN:   post    = POST_KICK;
      S_D_MUL:   mul_sel = MUL_V_TS;
      S_D_SUM:   post    = POST_DRIFT_S;
      S_D_DIV:   div_sel = DIV_WRAP;
      S_D_FIN:   post    = POST_DRIFT;
      S_E_SQ:    mul_sel = MUL_V_V;
      S_E_SQACC: post    = POST_SQ;
      S_E_MUL:   mul_sel = MUL_SQ_M;
      S_E_DIV:   div_sel = DIV_ENERGY;
      S_E_ACC:   post    = POST_ENERGY;
      S_T_MUL:   mul_sel = MUL_KB_N;
      S_T_DIV:   div_sel = DIV_TEMP;
      S_T_FIN:   post    = POST_TEMP;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 2'd0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            axis_q  <= 2'd0;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (sts_i.op)
            OP_KICK: begin
              state_q  <= S_K_MUL1;
              mul_go_q <= 1'b1;
            end
            OP_DRIFT: begin
              state_q  <= S_D_MUL;
              mul_go_q <= 1'b1;
            end
            OP_ENERGY: begin
              state_q  <= S_E_SQ;
              mul_go_q <= 1'b1;
            end
            OP_NONE: state_q <= S_DONE;
          endcase
        end
        S_K_MUL1: begin
          if (sts_i.mul_done) begin
            state_q  <= S_K_MUL2;
            mul_go_q <= 1'b1;
          end
        end
        S_K_MUL2: begin
          if (sts_i.mul_done) begin
            state_q  <= S_K_DIV;
            div_go_q <= 1'b1;
          end
        end
        S_K_DIV: begin
          if (sts_i.div_done) state_q <= S_K_FIN;
        end
        S_K_FIN: begin
          if (axis_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            axis_q   <= axis_q + 2'd1;
            state_q  <= S_K_MUL1;
            mul_go_q <= 1'b1;
          end
        end
        S_D_MUL: begin
          if (sts_i.mul_done) state_q <= S_D_SUM;
        end
        S_D_SUM: begin
          state_q  <= S_D_DIV;
          div_go_q <= 1'b1;
        end
        S_D_DIV: begin
          if (sts_i.div_done) state_q <= S_D_FIN;
        end
        S_D_FIN: begin
          if (axis_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            axis_q   <= axis_q + 2'd1;
            state_q  <= S_D_MUL;
            mul_go_q <= 1'b1;
          end
        end
        S_E_SQ: begin
          if (sts_i.mul_done) state_q <= S_E_SQACC;
        end
        S_E_SQACC: begin
          mul_go_q <= 1'b1;
          if (axis_q == 2'd2) begin
            axis_q  <= 2'd0;
            state_q <= S_E_MUL;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_E_SQ;
          end
        end
        S_E_MUL: begin
          if (sts_i.mul_done) begin
            state_q  <= S_E_DIV;
            div_go_q <= 1'b1;
          end
        end
        S_E_DIV: begin
          if (sts_i.div_done) state_q <= S_E_ACC;
        end
        S_E_ACC: begin
          if (sts_i.last) begin
            state_q  <= S_T_MUL;
            mul_go_q <= 1'b1;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_T_MUL: begin
          if (sts_i.mul_done) begin
            state_q  <= S_T_DIV;
            div_go_q <= 1'b1;
          end
        end
        S_T_DIV: begin
          if (sts_i.div_done) state_q <= S_T_FIN;
        end
        S_T_FIN: state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_o.load     = load;
  assign cmd_o.mul_go   = mul_go_q;
  assign cmd_o.mul_sel  = mul_sel;
  assign cmd_o.div_go   = div_go_q;
  assign cmd_o.div_sel  = div_sel;
  assign cmd_o.post     = post;
  assign cmd_o.axis     = axis_q;
  assign cmd_o.out_load = out_load;
  assign out_valid_o    = out_valid_q;

  // the two shared units are never launched together
  a_go_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_go_q && div_go_q))
    else $error("multiplier and divider started together");

  // a multiplier result only arrives while the sequencer waits for one
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == S_K_MUL1 || state_q == S_K_MUL2 ||
                        state_q == S_D_MUL || state_q == S_E_SQ ||
                        state_q == S_E_MUL || state_q == S_T_MUL))
    else $error("multiplier done outside a multiply state");

  // a divider result only arrives while the sequencer waits for one
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_K_DIV || state_q == S_D_DIV ||
                        state_q == S_E_DIV || state_q == S_T_DIV))
    else $error("divider done outside a divide state");

  // energy accumulation only runs for an energy word
  a_energy_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E_ACC) |-> (sts_i.op == OP_ENERGY))
    else $error("energy update for a non-energy word");

endmodule

// ----- hw/rtl/verlet_atom_integrator.sv -----
`timescale 1ns / 1ps
// work per word: half kick runs two multiplies and a divide on each of the 3 axes,
//   drift a multiply and a divide on each axis, energy a squaring multiply per axis,
//   a mass multiply and a divide, plus a multiply and divide for temperature on the last atom of a pass
// throughput: one word at a time, set by the shared bit-serial multiplier and divider
// the next word is taken while the previous result waits in the output register
// reset: async active low, registers to defaults, energy sum and atom count cleared
module verlet_atom_integrator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  vai_pkg::vai_in_t            in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output vai_pkg::vai_out_t           out_word_o,
  input  logic                        cfg_we_i,
  input  logic [vai_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vai_pkg::CfgW-1:0]    cfg_data_i
);
  import vai_pkg::*;

  vai_cmd_t cmd;
  vai_sts_t sts;

  // sequencer
  vai_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  vai_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

// ----- bench/tb_verlet_atom_integrator.sv -----
`timescale 1ns / 1ps
module tb_verlet_atom_integrator;
  import vai_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned AtomLimit = 4096;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  vai_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  vai_out_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  verlet_atom_integrator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // mirrored registers and energy state
  logic [31:0] box_len, step_len, conv_fac;
  logic [39:0] kb_val;
  logic [47:0] ke_sum;
  int unsigned atom_cnt;

  vai_in_t atom_q[$];
  vai_out_t update_q[$];
  int unsigned err_cnt = 0;
  int unsigned accepted_in = 0;
  bit hold_done = 1'b0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // append one word to the pending stimulus
  task automatic queue_atom(vai_in_t a);
    atom_q = {atom_q, a};
  endtask

  function automatic longint clamp32(longint x, inout bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint floor_div(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // expected update for one atom word, advances the energy state
  function automatic vai_out_t integrate_atom(vai_in_t a);
    vai_out_t r;
    longint pos[3], vel[3], frc[3], res[3], wr[3];
    logic [63:0] mag, m;
    logic [127:0] num, den, q;
    logic [63:0] sumsq;
    longint dp, s, len, n;
    bit flag, sat;
    op_e op;
    r = '0;
    flag = 1'b0;
    sat = 1'b0;
    op = op_e'(a.op);
    pos = '{longint'(a.pos_x), longint'(a.pos_y), longint'(a.pos_z)};
    vel = '{longint'(a.vel_x), longint'(a.vel_y), longint'(a.vel_z)};
    frc = '{longint'(a.force_x), longint'(a.force_y), longint'(a.force_z)};
    res = '{0, 0, 0};
    wr = '{0, 0, 0};
    case (op)
      OP_KICK: begin
        for (int k = 0; k < 3; k++) begin
          if (a.mass == 0) begin
            flag = 1'b1;
            res[k] = vel[k];
          end else begin
            mag = frc[k] < 0 ? -frc[k] : frc[k];
            num = 128'(mag * 64'(step_len)) * 128'(conv_fac);
            den = 128'(a.mass) << 31;
            q = num / den;
            if (q > (128'd1 << 33)) begin
              sat = 1'b1;
              res[k] = frc[k] < 0 ? -64'sd2147483648 : 64'sd2147483647;
            end else begin
              res[k] = clamp32(frc[k] < 0 ? vel[k] - longint'(q[63:0])
                                          : vel[k] + longint'(q[63:0]), sat);
            end
          end
        end
      end
      OP_DRIFT: begin
        for (int k = 0; k < 3; k++) begin
          mag = vel[k] < 0 ? -vel[k] : vel[k];
          m = mag * 64'(step_len);
          dp = longint'(m >> 36);
          if (vel[k] < 0) dp = -(dp + ((m[35:0] != 0) ? 1 : 0));
          s = pos[k] + dp;
          if (box_len == 0) begin
            flag = 1'b1;
            res[k] = clamp32(s, sat);
          end else begin
            len = longint'({32'd0, box_len});
            n = floor_div(2 * s + len, 2 * len);
            res[k] = s - n * len;
            if (n > 127) begin
              n = 127;
              sat = 1'b1;
            end
            if (n < -128) begin
              n = -128;
              sat = 1'b1;
            end
            wr[k] = n;
          end
        end
      end
      OP_ENERGY: begin
        sumsq = '0;
        for (int k = 0; k < 3; k++) begin
          mag = vel[k] < 0 ? -vel[k] : vel[k];
          sumsq += mag * mag;
        end
        if (a.mass == 0) flag = 1'b1;
        if (conv_fac == 0) begin
          flag = 1'b1;
        end else begin
          q = (128'(a.mass) * 128'(sumsq)) / (128'(conv_fac) << 15);
          if (q > 128'({48{1'b1}} - ke_sum)) begin
            ke_sum = {48{1'b1}};
            sat = 1'b1;
          end else begin
            ke_sum += q[47:0];
          end
        end
        if (atom_cnt < AtomLimit) atom_cnt++;
        else sat = 1'b1;
        r.kinetic_total = ke_sum;
        if (a.last_atom) begin
          if (kb_val == 0) begin
            flag = 1'b1;
          end else begin
            q = (128'(ke_sum) << 33) / (128'(3 * atom_cnt) * 128'(kb_val));
            if (q > 128'(32'hffff_ffff)) begin
              r.temperature_k = '1;
              sat = 1'b1;
            end else begin
              r.temperature_k = q[31:0];
            end
          end
          ke_sum = '0;
          atom_cnt = 0;
        end
        r.result_last = a.last_atom;
      end
      default: ;
    endcase
    r.new_a = res[0][31:0];
    r.new_b = res[1][31:0];
    r.new_c = res[2][31:0];
    r.wrap_x = wr[0][7:0];
    r.wrap_y = wr[1][7:0];
    r.wrap_z = wr[2][7:0];
    r.status = sat ? ST_SAT : (flag ? ST_FLAG : ST_OK);
    return r;
  endfunction

  // sender: bursts of words with gaps between them
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        update_q = {update_q, integrate_atom(in_word_i)};
        accepted_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (atom_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_word_i <= atom_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 600);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (!hold_done && accepted_in >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(200, 3000);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 0);
        2: out_stall_i <= ($urandom_range(0, 9) != 0);
        default: out_stall_i <= ($urandom_range(0, 49) < 2);
      endcase
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    vai_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (update_q.size() == 0) begin
        report("unexpected word", 64'(out_word_o.kinetic_total), '0);
      end else begin
        want = update_q.pop_front();
        if (out_word_o.new_a !== want.new_a)
          report("new_a", 64'(out_word_o.new_a), 64'(want.new_a));
        if (out_word_o.new_b !== want.new_b)
          report("new_b", 64'(out_word_o.new_b), 64'(want.new_b));
        if (out_word_o.new_c !== want.new_c)
          report("new_c", 64'(out_word_o.new_c), 64'(want.new_c));
        if (out_word_o.wrap_x !== want.wrap_x)
          report("wrap_x", 64'(out_word_o.wrap_x), 64'(want.wrap_x));
        if (out_word_o.wrap_y !== want.wrap_y)
          report("wrap_y", 64'(out_word_o.wrap_y), 64'(want.wrap_y));
        if (out_word_o.wrap_z !== want.wrap_z)
          report("wrap_z", 64'(out_word_o.wrap_z), 64'(want.wrap_z));
        if (out_word_o.kinetic_total !== want.kinetic_total)
          report("kinetic_total", 64'(out_word_o.kinetic_total), 64'(want.kinetic_total));
        if (out_word_o.temperature_k !== want.temperature_k)
          report("temperature_k", 64'(out_word_o.temperature_k), 64'(want.temperature_k));
        if (out_word_o.status !== want.status)
          report("status", 64'(out_word_o.status), 64'(want.status));
        if (out_word_o.result_last !== want.result_last)
          report("result_last", 64'(out_word_o.result_last), 64'(want.result_last));
      end
    end
  end

  // watchdog on cycles with no traffic at all
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("verlet_atom_integrator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [39:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BOX: box_len = val[31:0];
      CFG_TS:  step_len = val[31:0];
      CFG_FTA: conv_fac = val[31:0];
      default: kb_val = val;
    endcase
  endtask

  task automatic set_regs(logic [31:0] box, logic [31:0] ts, logic [31:0] fta,
                          logic [39:0] kb);
    write_reg(CFG_BOX, 40'(box));
    write_reg(CFG_TS, 40'(ts));
    write_reg(CFG_FTA, 40'(fta));
    write_reg(CFG_KB, kb);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (atom_q.size() != 0 || in_valid_i || update_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic vai_in_t atom_word(op_e op, logic [31:0] p, logic [31:0] v,
                                        logic [31:0] f, logic [23:0] mass, logic last);
    vai_in_t a;
    a = '{op: op, pos_x: p, pos_y: -p, pos_z: p >>> 3, vel_x: v, vel_y: -v,
          vel_z: v >>> 2, force_x: f, force_y: -f, force_z: f >>> 5,
          mass: mass, last_atom: last};
    return a;
  endfunction

  function automatic logic [31:0] small_val(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // random atom: mostly physical values, some full-range noise
  function automatic vai_in_t random_atom();
    vai_in_t a;
    int unsigned sel;
    a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, 27'($urandom)};
    sel = $urandom_range(0, 9);
    a.op = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 19) == 0) a.op = OP_NONE;
    if (sel < 7) begin
      a.pos_x = small_val(box_len[31:1] + 32'h10000);
      a.pos_y = small_val(box_len[31:1] + 32'h10000);
      a.pos_z = small_val(box_len[31:1] + 32'h10000);
      a.vel_x = small_val(32'h0080_0000);
      a.vel_y = small_val(32'h0080_0000);
      a.vel_z = small_val(32'h0080_0000);
      a.force_x = small_val(32'h0040_0000);
      a.force_y = small_val(32'h0040_0000);
      a.force_z = small_val(32'h0040_0000);
      a.mass = 24'($urandom_range(16384, 200 << 14));
    end
    if ($urandom_range(0, 24) == 0) a.mass = '0;
    a.last_atom = ($urandom_range(0, 5) == 0);
    return a;
  endfunction

  task automatic random_phase(int unsigned count);
    repeat (count) queue_atom(random_atom());
    drain();
  endtask

  initial begin
    box_len = BoxRst;
    step_len = TsRst;
    conv_fac = FtaRst;
    kb_val = KbRst;
    ke_sum = '0;
    atom_cnt = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero mass, wrapping, energy pass, unused op
    set_regs(32'h0005_0000, TsRst, FtaRst, KbRst);
    queue_atom(atom_word(OP_KICK, 0, 32'h0100_0000, 32'h7fff_ffff, 24'd1, 1'b0));
    queue_atom(atom_word(OP_KICK, 0, 32'h8000_0000, 32'h8000_0000, 24'hff_ffff, 1'b0));
    queue_atom(atom_word(OP_KICK, 0, 32'h7fff_ffff, 32'h0001_0000, 24'h00_4000, 1'b0));
    queue_atom(atom_word(OP_KICK, 0, 32'h0123_4567, 32'h0002_0000, 24'd0, 1'b0));
    queue_atom(atom_word(OP_DRIFT, 32'h0002_8000, 32'h0200_0000, 0, 24'h4000, 1'b0));
    queue_atom(atom_word(OP_DRIFT, 32'h7fff_ffff, 32'h7fff_ffff, 0, 24'h4000, 1'b0));
    queue_atom(atom_word(OP_DRIFT, 32'h8000_0000, 32'h8000_0000, 0, 24'h4000, 1'b0));
    queue_atom(atom_word(OP_ENERGY, 0, 32'h0100_0000, 0, 24'h4000, 1'b0));
    queue_atom(atom_word(OP_ENERGY, 0, 32'h8000_0000, 0, 24'hff_ffff, 1'b0));
    queue_atom(atom_word(OP_ENERGY, 0, 32'h0001_0000, 0, 24'd0, 1'b1));
    queue_atom(atom_word(OP_NONE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         24'hff_ffff, 1'b1));
    drain();
    // tiny box saturates the image counts
    set_regs(32'd1, 32'hffff_ffff, 32'hffff_ffff, 40'd1);
    queue_atom(atom_word(OP_DRIFT, 32'h4000_0000, 32'h7fff_ffff, 0, 24'h4000, 1'b0));
    queue_atom(atom_word(OP_KICK, 0, 0, 32'h7fff_ffff, 24'd1, 1'b0));
    queue_atom(atom_word(OP_ENERGY, 0, 32'h7fff_ffff, 0, 24'hff_ffff, 1'b1));
    drain();
    // no box, zero conversion and zero Boltzmann constant
    set_regs(32'd0, 32'hffff_ffff, 32'd0, 40'd0);
    queue_atom(atom_word(OP_DRIFT, 32'h7fff_0000, 32'h7fff_ffff, 0, 24'h4000, 1'b0));
    queue_atom(atom_word(OP_DRIFT, 32'h0001_0000, 32'h0000_1000, 0, 24'h4000, 1'b0));
    queue_atom(atom_word(OP_ENERGY, 0, 32'h0100_0000, 0, 24'h4000, 1'b1));
    drain();

    // random phases over several register settings
    set_regs(BoxRst, TsRst, FtaRst, KbRst);
    random_phase(100);
    set_regs(32'h0020_0000, TsRst, FtaRst, KbRst);
    random_phase(120);
    set_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 40'hff_ffff_ffff);
    random_phase(60);
    set_regs(32'h0000_8000, 32'd0, 32'd1, 40'd1);
    random_phase(60);
    repeat (4) begin
      set_regs($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0040_0000),
               $urandom_range(0, 32'h4000_0000), $urandom_range(1, 32'h0010_0000),
               40'({$urandom, $urandom}));
      random_phase(65);
    end

    repeat (600) @(posedge clk_i);
    if (err_cnt == 0 && update_q.size() == 0) begin
      $display("verlet_atom_integrator verification clean");
    end else begin
      $display("verlet_atom_integrator verification failed");
    end
    $finish;
  end

endmodule

// ----- verlet_atom_integrator.f -----
hw/rtl/vai_pkg.sv
hw/rtl/vai_mul.sv
hw/rtl/vai_div.sv
hw/rtl/vai_dp.sv
hw/rtl/vai_ctrl.sv
hw/rtl/verlet_atom_integrator.sv
bench/tb_verlet_atom_integrator.sv
